>>> rtl/hbl_pkg.sv
// shared types and constants for the hex byte list parser
package hbl_pkg;

   // depth of the word queue between the classifier and the parser
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   // characters with a meaning of their own
   localparam logic [7:0] CHAR_END   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_COMMA = 8'h2C;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_LOW_X = 8'h78;
   localparam logic [7:0] CHAR_UP_X  = 8'h58;

   // offset that turns the low bits of a letter digit into its value
   localparam logic [3:0] LETTER_OFFSET = 4'd9;

   // class of one character
   typedef enum logic [2:0] {
      CLS_END,
      CLS_SEP,
      CLS_ZERO,
      CLS_X,
      CLS_HEX,
      CLS_OTHER
   } char_class_type;

   // classified character as it travels through the queue
   typedef struct packed {
      char_class_type cls;
      logic [3:0]     nibble;
   } char_word_type;

   // parser phase
   typedef enum logic [2:0] {
      PH_SEP,
      PH_ZERO,
      PH_PREFIXED,
      PH_HIGH_HELD,
      PH_BYTE_HELD
   } phase_type;

   // status codes of the closing result
   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_BAD_HEX     = 3'd1,
      ST_NEEDS_TWO   = 3'd2,
      ST_TOO_LONG    = 3'd3,
      ST_TOO_MANY    = 3'd4,
      ST_MISSING_SEP = 3'd5,
      ST_NO_BYTES    = 3'd6
   } status_type;

   // one result word
   typedef struct packed {
      logic       is_status;
      logic [7:0] data_byte;
      status_type status_code;
      logic [7:0] byte_count;
      logic       last;
   } result_type;

endpackage

>>> rtl/hex_byte_list_parser.sv
// top level of the hex byte list parser
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_stall  | req_character
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_is_status, rsp_data_byte,
//          |           |                      | rsp_status_code, rsp_byte_count, rsp_last
//
// One character is taken per cycle while req_stall is low; a result passes through the word
// queue and then the output register.
// A byte followed by end of text gives two results and holds the parser
// while the status word leaves the held register.
// req_stall rises when the four-word queue is full; rsp_stall freezes a valid output register
// and stops the parser taking words.
// Reset clears the queue pointers, the parser state and the result valid flags.
module hex_byte_list_parser #(
   parameter int MAX_BYTES = 64
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_character,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_is_status,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_status_code,
   output logic [7:0] rsp_byte_count,
   output logic       rsp_last
);

   logic                   push;
   hbl_pkg::char_word_type push_word;
   logic                   pop;
   hbl_pkg::char_word_type head_word;
   logic                   empty;
   logic                   full;
   hbl_pkg::result_type    rsp_result;

   // classifier
   hbl_front u_front (
      .req_valid     (req_valid),
      .req_character (req_character),
      .req_stall     (req_stall),
      .queue_full    (full),
      .push          (push),
      .push_word     (push_word)
   );

   // word queue
   hbl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_word (push_word),
      .pop       (pop),
      .head_word (head_word),
      .empty     (empty),
      .full      (full)
   );

   // parser and result registers
   hbl_back #(
      .MAX_BYTES (MAX_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_word  (head_word),
      .empty      (empty),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_result (rsp_result)
   );

   // result fields
   assign rsp_is_status   = rsp_result.is_status;
   assign rsp_data_byte   = rsp_result.data_byte;
   assign rsp_status_code = rsp_result.status_code;
   assign rsp_byte_count  = rsp_result.byte_count;
   assign rsp_last        = rsp_result.last;

endmodule

>>> rtl/hbl_front.sv
// front end: takes characters and classifies them into queue words
module hbl_front (
   input  logic                   req_valid,
   input  logic [7:0]             req_character,
   output logic                   req_stall,
   input  logic                   queue_full,
   output logic                   push,
   output hbl_pkg::char_word_type push_word
);

   logic [7:0] ch;

   assign ch = req_character;

   // stall while the queue has no room
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;

   // character class and digit value
   always_comb begin
      push_word.nibble = ch[3:0];
      if (ch == hbl_pkg::CHAR_END) begin
         push_word.cls = hbl_pkg::CLS_END;
      end else if (ch inside {[8'd9:8'd13], hbl_pkg::CHAR_SPACE, hbl_pkg::CHAR_COMMA,
                              hbl_pkg::CHAR_SEMI}) begin
         push_word.cls = hbl_pkg::CLS_SEP;
      end else if (ch == hbl_pkg::CHAR_ZERO) begin
         push_word.cls = hbl_pkg::CLS_ZERO;
      end else if (ch == hbl_pkg::CHAR_LOW_X || ch == hbl_pkg::CHAR_UP_X) begin
         push_word.cls = hbl_pkg::CLS_X;
      end else if (ch inside {[8'h31:8'h39]}) begin
         push_word.cls = hbl_pkg::CLS_HEX;
      end else if (ch inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         push_word.cls    = hbl_pkg::CLS_HEX;
         push_word.nibble = ch[3:0] + hbl_pkg::LETTER_OFFSET;
      end else begin
         push_word.cls = hbl_pkg::CLS_OTHER;
      end
   end

endmodule

>>> rtl/hbl_fifo.sv
// short word queue between the classifier and the parser
module hbl_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  hbl_pkg::char_word_type push_word,
   input  logic                   pop,
   output hbl_pkg::char_word_type head_word,
   output logic                   empty,
   output logic                   full
);

   localparam int AW = hbl_pkg::QUEUE_AW;
   localparam logic [AW:0] DEPTH = (AW + 1)'(hbl_pkg::QUEUE_DEPTH);

   hbl_pkg::char_word_type entry_ff [hbl_pkg::QUEUE_DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [AW:0]   count_ff, count_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == DEPTH);
   assign head_word = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // word storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

>>> rtl/hbl_back.sv
// back end: token parser, result register and held status word
module hbl_back #(
   parameter int MAX_BYTES = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   input  hbl_pkg::char_word_type head_word,
   input  logic                   empty,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output hbl_pkg::result_type    rsp_result
);

   localparam logic [7:0] MAX_COUNT = 8'(MAX_BYTES);

   hbl_pkg::phase_type  phase_ff, phase_in;
   hbl_pkg::status_type error_ff, error_in;
   hbl_pkg::status_type error_new;
   hbl_pkg::status_type status_code;
   logic [3:0]          high_ff, high_in;
   logic [7:0]          pending_ff, pending_in;
   logic [7:0]          count_ff, count_in;
   logic [7:0]          count_inc;

   logic                is_digit;
   logic                is_end;
   logic                emit_data;
   logic                emit_status;
   hbl_pkg::result_type data_result;
   hbl_pkg::result_type status_result;

   logic                rsp_valid_ff, rsp_valid_in;
   hbl_pkg::result_type rsp_ff, rsp_in;
   logic                held_valid_ff, held_valid_in;
   hbl_pkg::result_type held_ff, held_in;
   logic                out_free;

   assign is_digit  = (head_word.cls == hbl_pkg::CLS_HEX) ||
                      (head_word.cls == hbl_pkg::CLS_ZERO);
   assign is_end    = (head_word.cls == hbl_pkg::CLS_END);
   assign count_inc = count_ff + 8'd1;

   // take a word only when no held status waits and the output slot frees
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign pop      = !empty && !held_valid_ff && out_free;

   // next state of the parser
   always_comb begin
      phase_in   = phase_ff;
      error_in   = error_ff;
      high_in    = high_ff;
      pending_in = pending_ff;
      count_in   = count_ff;
      error_new  = hbl_pkg::ST_OK;
      case (phase_ff)
         hbl_pkg::PH_SEP: begin
            if (head_word.cls == hbl_pkg::CLS_ZERO) begin
               phase_in = hbl_pkg::PH_ZERO;
            end else if (head_word.cls == hbl_pkg::CLS_HEX) begin
               high_in  = head_word.nibble;
               phase_in = hbl_pkg::PH_HIGH_HELD;
            end else if (!is_end && head_word.cls != hbl_pkg::CLS_SEP) begin
               error_new = hbl_pkg::ST_BAD_HEX;
            end
         end
         hbl_pkg::PH_ZERO: begin
            if (head_word.cls == hbl_pkg::CLS_X) begin
               phase_in = hbl_pkg::PH_PREFIXED;
            end else begin
               high_in = 4'h0;
               if (is_digit) begin
                  pending_in = {4'h0, head_word.nibble};
                  phase_in   = hbl_pkg::PH_BYTE_HELD;
               end else begin
                  error_new = hbl_pkg::ST_NEEDS_TWO;
               end
            end
         end
         hbl_pkg::PH_PREFIXED: begin
            if (is_digit) begin
               high_in  = head_word.nibble;
               phase_in = hbl_pkg::PH_HIGH_HELD;
            end else begin
               error_new = hbl_pkg::ST_BAD_HEX;
            end
         end
         hbl_pkg::PH_HIGH_HELD: begin
            if (is_digit) begin
               pending_in = {high_ff, head_word.nibble};
               phase_in   = hbl_pkg::PH_BYTE_HELD;
            end else begin
               error_new = hbl_pkg::ST_NEEDS_TWO;
            end
         end
         hbl_pkg::PH_BYTE_HELD: begin
            if (is_digit) begin
               error_new = hbl_pkg::ST_TOO_LONG;
            end else if (count_ff >= MAX_COUNT) begin
               error_new = hbl_pkg::ST_TOO_MANY;
            end else begin
               count_in = count_inc;
               phase_in = hbl_pkg::PH_SEP;
               if (!is_end && head_word.cls != hbl_pkg::CLS_SEP) begin
                  error_new = hbl_pkg::ST_MISSING_SEP;
               end
            end
         end
         default: begin
            phase_in = hbl_pkg::PH_SEP;
         end
      endcase
      // after an error only the end of text matters
      if (error_ff != hbl_pkg::ST_OK) begin
         phase_in   = phase_ff;
         high_in    = high_ff;
         pending_in = pending_ff;
         count_in   = count_ff;
      end else if (error_new != hbl_pkg::ST_OK) begin
         error_in = error_new;
      end
      // end of text always closes the text
      if (is_end) begin
         phase_in   = hbl_pkg::PH_SEP;
         error_in   = hbl_pkg::ST_OK;
         high_in    = 4'h0;
         pending_in = 8'h00;
         count_in   = 8'h00;
      end
   end

   // results caused by the word at the head of the queue
   always_comb begin
      emit_data   = (error_ff == hbl_pkg::ST_OK) && (phase_ff == hbl_pkg::PH_BYTE_HELD) &&
                    !is_digit && (count_ff < MAX_COUNT);
      emit_status = is_end;
      if (error_ff != hbl_pkg::ST_OK) begin
         status_code = error_ff;
      end else if (error_new != hbl_pkg::ST_OK) begin
         status_code = error_new;
      end else if (phase_ff == hbl_pkg::PH_SEP && count_ff == 8'd0) begin
         status_code = hbl_pkg::ST_NO_BYTES;
      end else begin
         status_code = hbl_pkg::ST_OK;
      end
      data_result.is_status   = 1'b0;
      data_result.data_byte   = pending_ff;
      data_result.status_code = hbl_pkg::ST_OK;
      data_result.byte_count  = count_inc;
      data_result.last        = 1'b0;
      status_result.is_status   = 1'b1;
      status_result.data_byte   = 8'h00;
      status_result.status_code = status_code;
      status_result.byte_count  = emit_data ? count_inc : count_ff;
      status_result.last        = 1'b1;
   end

   // output register and held status word
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      if (out_free) begin
         rsp_valid_in = 1'b0;
      end
      if (held_valid_ff) begin
         if (out_free) begin
            rsp_in        = held_ff;
            rsp_valid_in  = 1'b1;
            held_valid_in = 1'b0;
         end
      end else if (pop) begin
         if (emit_data) begin
            rsp_in       = data_result;
            rsp_valid_in = 1'b1;
            if (emit_status) begin
               held_in       = status_result;
               held_valid_in = 1'b1;
            end
         end else if (emit_status) begin
            rsp_in       = status_result;
            rsp_valid_in = 1'b1;
         end
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= hbl_pkg::PH_SEP;
         error_ff   <= hbl_pkg::ST_OK;
         high_ff    <= 4'h0;
         pending_ff <= 8'h00;
         count_ff   <= 8'h00;
      end else if (pop) begin
         phase_ff   <= phase_in;
         error_ff   <= error_in;
         high_ff    <= high_in;
         pending_ff <= pending_in;
         count_ff   <= count_in;
      end
   end

   // result valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         held_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // result payloads
   always_ff @(posedge clock) begin
      rsp_ff  <= rsp_in;
      held_ff <= held_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_ff;

   // a held status only exists behind an occupied output register
   a_held_behind_out: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> rsp_valid_ff)
      else $error("held status without an output word");

   // the held word is always the closing status
   a_held_is_status: assert property (@(posedge clock) disable iff (reset)
      held_valid_ff |-> (held_ff.is_status && held_ff.last))
      else $error("held word is not a closing status");

   // last marks exactly the status words
   a_last_on_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last == rsp_ff.is_status))
      else $error("last flag disagrees with status flag");

   // a data word always counts itself
   a_data_counted: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.is_status) |-> (rsp_ff.byte_count != 8'd0))
      else $error("data word with zero byte count");

endmodule
